// ===== design/nearest_four_light_select_top_defines.svh =====
// Assertion macros used by the nearest-light selector top level.
`ifndef NEAREST_FOUR_LIGHT_SELECT_TOP_DEFINES_SVH
`define NEAREST_FOUR_LIGHT_SELECT_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define NFL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define NFL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/nfl_pkg.sv =====
// Types and constants shared by the nearest-light selector.
package nfl_pkg;

	localparam int COORD_W        = 16;
	localparam int DIFF_W         = COORD_W + 1;
	localparam int SQ_W           = 2 * COORD_W;
	localparam int DIST_W         = SQ_W + 2;
	localparam int IDX_W          = 8;
	localparam int SLOT_W         = 2;
	localparam int KEEP_COUNT_DEF = 4;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_OBJECT_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OBJECT_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OBJECT_Z = 2'd2;

	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] dsq;
		logic [IDX_W-1:0]  idx;
	} nfl_entry_t;

	// A light whose distance is known, on its way into the cell row.
	typedef struct packed {
		logic              vld;
		logic              last;
		logic [DIST_W-1:0] dsq;
		logic [IDX_W-1:0]  idx;
	} nfl_cand_t;

	typedef struct packed {
		logic ins;
		logic drain;
	} nfl_cell_ctl_t;

	localparam nfl_entry_t ENTRY_EMPTY = '{valid: 1'b0, dsq: '1, idx: '0};

endpackage

// ===== design/nfl_ifs.sv =====
// Request channels: lights in, slot results out.
interface nfl_light_if;
	import nfl_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] light_x;
	logic signed [COORD_W-1:0] light_y;
	logic signed [COORD_W-1:0] light_z;
	logic [IDX_W-1:0]          light_index;
	logic                      batch_end;
	modport source (output valid, light_x, light_y, light_z, light_index, batch_end,
		input ready);
	modport sink (input valid, light_x, light_y, light_z, light_index, batch_end,
		output ready);
endinterface

interface nfl_slot_if;
	import nfl_pkg::*;
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] slot;
	logic              exists;
	logic [IDX_W-1:0]  chosen_index;
	logic [DIST_W-1:0] distance_sq;
	logic              final_slot;
	modport source (output valid, slot, exists, chosen_index, distance_sq, final_slot,
		input ready);
	modport sink (input valid, slot, exists, chosen_index, distance_sq, final_slot,
		output ready);
endinterface

// ===== design/nfl_dist.sv =====
// Three-stage pipeline forming the squared distance of a light to the object.
module nfl_dist (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic signed [nfl_pkg::COORD_W-1:0] light_x,
	input  logic signed [nfl_pkg::COORD_W-1:0] light_y,
	input  logic signed [nfl_pkg::COORD_W-1:0] light_z,
	input  logic [nfl_pkg::IDX_W-1:0]         light_index,
	input  logic                              batch_end,
	input  logic signed [nfl_pkg::COORD_W-1:0] object_x,
	input  logic signed [nfl_pkg::COORD_W-1:0] object_y,
	input  logic signed [nfl_pkg::COORD_W-1:0] object_z,
	output nfl_pkg::nfl_cand_t                cand
);
	import nfl_pkg::*;

	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [IDX_W-1:0]         idx_s1, idx_s2, idx_s3;
	logic                     last_s1, last_s2, last_s3;
	logic                     vld_s1, vld_s2, vld_s3;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2, sqz_s2;
	logic [DIST_W-1:0]        dist_s3;
	logic [SQ_W-1:0]          px, py, pz;

	// Squares of 17-bit differences are non-negative and fit 32 bits.
	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= {light_x[COORD_W-1], light_x} - {object_x[COORD_W-1], object_x};
		dy_s1   <= {light_y[COORD_W-1], light_y} - {object_y[COORD_W-1], object_y};
		dz_s1   <= {light_z[COORD_W-1], light_z} - {object_z[COORD_W-1], object_z};
		idx_s1  <= light_index;
		last_s1 <= batch_end;
		sqx_s2  <= px;
		sqy_s2  <= py;
		sqz_s2  <= pz;
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		dist_s3 <= DIST_W'(sqx_s2) + DIST_W'(sqy_s2) + DIST_W'(sqz_s2);
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
	end

	assign cand = '{vld: vld_s3, last: last_s3, dsq: dist_s3, idx: idx_s3};

endmodule

// ===== design/nfl_cell.sv =====
// One rank of the kept list: holds an entry, inserts or shifts from its neighbours.
module nfl_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nfl_pkg::nfl_cell_ctl_t ctl,
	input  nfl_pkg::nfl_cand_t    cand,
	input  nfl_pkg::nfl_entry_t   prev_ent,
	input  logic                  prev_keep,
	input  nfl_pkg::nfl_entry_t   next_ent,
	output nfl_pkg::nfl_entry_t   ent,
	output logic                  keep
);
	import nfl_pkg::*;

	logic              valid_q;
	logic [DIST_W-1:0] dsq_q;
	logic [IDX_W-1:0]  idx_q;
	nfl_entry_t        ent_d;

	assign ent = '{valid: valid_q, dsq: dsq_q, idx: idx_q};

	// An equal distance stays ahead of the newcomer.
	assign keep = valid_q && (dsq_q <= cand.dsq);

	always_comb begin
		ent_d = ent;
		if (ctl.drain) begin
			ent_d = next_ent;
		end else if (ctl.ins && !keep) begin
			if (prev_keep) begin
				ent_d = '{valid: 1'b1, dsq: cand.dsq, idx: cand.idx};
			end else begin
				ent_d = prev_ent;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ent_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		dsq_q <= ent_d.dsq;
		idx_q <= ent_d.idx;
	end

endmodule

// ===== design/nearest_four_light_select_top.sv =====
// Top level of the nearest-light selector: keeps the KEEP_COUNT nearest lights of a batch.
`include "nearest_four_light_select_top_defines.svh"

// Lights enter at one per cycle while input is open. Each passes a three-stage
// distance pipeline (difference, square, sum) and is then sorted into a row of
// KEEP_COUNT cells, all updating together, each cell comparing against the
// newcomer and keeping its entry or taking the newcomer or its neighbour's.
// After the light marked batch_end is accepted, input stays blocked while it
// passes the distance stages, and then for the KEEP_COUNT slot results, which
// leave nearest first as the row shifts towards cell 0; the row is empty when
// the last one is taken. The user must write object coordinates only while the
// block is idle; the block itself does not enforce it.
module nearest_four_light_select_top #(
	parameter int KEEP_COUNT = nfl_pkg::KEEP_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	nfl_light_if.sink                     lights,
	nfl_slot_if.source                    slots,
	input  logic                          cfg_we,
	input  logic [nfl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nfl_pkg::COORD_W-1:0]   cfg_data
);
	import nfl_pkg::*;

	localparam int CW = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

	logic signed [COORD_W-1:0] object_x_q, object_y_q, object_z_q;
	logic                      end_pend_q, draining_q;
	logic [CW-1:0]             slot_q;
	logic                      take, out_take, last_out;
	nfl_cand_t                 cand;
	nfl_cell_ctl_t             ctl;
	nfl_entry_t                ents [KEEP_COUNT];
	nfl_entry_t                prev_a [KEEP_COUNT];
	nfl_entry_t                next_a [KEEP_COUNT];
	logic [KEEP_COUNT-1:0]     keeps, prev_keep, vld_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_x_q <= '0;
			object_y_q <= '0;
			object_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OBJECT_X: object_x_q <= cfg_data;
				REG_OBJECT_Y: object_y_q <= cfg_data;
				REG_OBJECT_Z: object_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lights.ready = !draining_q && !end_pend_q;
	assign take         = lights.valid && lights.ready;
	assign out_take     = slots.valid && slots.ready;
	assign last_out     = (slot_q == CW'(KEEP_COUNT - 1));

	nfl_dist u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.light_x     (lights.light_x),
		.light_y     (lights.light_y),
		.light_z     (lights.light_z),
		.light_index (lights.light_index),
		.batch_end   (lights.batch_end),
		.object_x    (object_x_q),
		.object_y    (object_y_q),
		.object_z    (object_z_q),
		.cand        (cand)
	);

	assign ctl = '{ins: cand.vld, drain: out_take};

	for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_a[i]    = ENTRY_EMPTY;
			assign prev_keep[i] = 1'b1;
		end else begin : g_body
			assign prev_a[i]    = ents[i-1];
			assign prev_keep[i] = keeps[i-1];
		end
		if (i == KEEP_COUNT - 1) begin : g_tail
			assign next_a[i] = ENTRY_EMPTY;
		end else begin : g_link
			assign next_a[i] = ents[i+1];
		end
		assign vld_vec[i] = ents[i].valid;

		nfl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cand      (cand),
			.prev_ent  (prev_a[i]),
			.prev_keep (prev_keep[i]),
			.next_ent  (next_a[i]),
			.ent       (ents[i]),
			.keep      (keeps[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_pend_q <= 1'b0;
			draining_q <= 1'b0;
			slot_q     <= '0;
		end else begin
			if (take && lights.batch_end) begin
				end_pend_q <= 1'b1;
			end else if (cand.vld && cand.last) begin
				end_pend_q <= 1'b0;
			end
			if (cand.vld && cand.last) begin
				draining_q <= 1'b1;
			end else if (out_take && last_out) begin
				draining_q <= 1'b0;
			end
			if (out_take) begin
				slot_q <= last_out ? '0 : slot_q + 1'b1;
			end
		end
	end

	assign slots.valid        = draining_q;
	assign slots.slot         = SLOT_W'(slot_q);
	assign slots.exists       = ents[0].valid;
	assign slots.chosen_index = ents[0].valid ? ents[0].idx : '0;
	assign slots.distance_sq  = ents[0].valid ? ents[0].dsq : '0;
	assign slots.final_slot   = last_out;

	`NFL_ASSERT_NOW(a_no_insert_while_draining, draining_q, !cand.vld, "light inserted during drain")
	`NFL_ASSERT_NOW(a_kept_list_packed, 1'b1, ((vld_vec >> 1) & ~vld_vec) == '0, "kept list has a gap")
	`NFL_ASSERT_NEXT(a_drain_ends_empty, out_take && last_out, vld_vec == '0, "list not empty after batch")
	`NFL_ASSERT_NOW(a_slot_zero_at_start, $rose(draining_q), slot_q == '0, "drain starts mid-count")

endmodule
